FILE: sv/qsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfd_pkg
// Shared types, character codes and helpers of the query string form decoder.
// ----------------------------------------------------------------------------
package qsfd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    // Results a single beat can cause, and the output queue depth
    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 2;

    typedef struct packed {
        logic       in_value_field;
        logic [1:0] escape_phase;
        logic [3:0] high_nibble;
        logic       high_nibble_ok;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
        logic       pair_has_value;
        logic       string_done;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

endpackage

FILE: sv/qsfd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfd_decode
// Segment and percent-escape state with the per-byte decode step.
// ----------------------------------------------------------------------------
module qsfd_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      ch,
    input  logic            last,
    input  logic            fire,
    output qsfd_pkg::step_t step
);
    import qsfd_pkg::*;

    dec_state_t state_reg;
    dec_state_t state_next;
    result_t    data_res;
    logic       data_emit;
    logic       is_sep;
    logic [4:0] hex;
    logic [1:0] kind_cur;

    assign is_sep   = (ch == CHAR_AMP) || (ch == CHAR_SEMI);
    assign hex      = hex_nibble(ch);
    assign kind_cur = state_reg.in_value_field ? KIND_VALUE : KIND_NAME;

    always_comb
    begin
        state_next = state_reg;
        data_emit  = 1'b0;
        data_res   = '0;
        if (is_sep)
        begin
            data_emit               = 1'b1;
            data_res.item_kind      = KIND_END;
            data_res.pair_has_value = state_reg.in_value_field;
            state_next              = '0;
        end
        else if (ch == CHAR_EQUALS && !state_reg.in_value_field)
        begin
            state_next                = '0;
            state_next.in_value_field = 1'b1;
        end
        else if (state_reg.escape_phase == ESC_FIRST)
        begin
            state_next.high_nibble_ok = hex[4];
            state_next.high_nibble    = hex[3:0];
            state_next.escape_phase   = ESC_SECOND;
        end
        else if (state_reg.escape_phase != ESC_IDLE)
        begin
            // drop the whole escape when either digit is not hex
            if (hex[4] && state_reg.high_nibble_ok)
            begin
                data_emit          = 1'b1;
                data_res.out_byte  = {state_reg.high_nibble, hex[3:0]};
                data_res.item_kind = kind_cur;
            end
            state_next.escape_phase   = ESC_IDLE;
            state_next.high_nibble    = 4'd0;
            state_next.high_nibble_ok = 1'b0;
        end
        else if (ch == CHAR_PERCENT)
        begin
            state_next.escape_phase = ESC_FIRST;
        end
        else
        begin
            data_emit          = 1'b1;
            data_res.out_byte  = (ch == CHAR_PLUS) ? CHAR_SPACE : ch;
            data_res.item_kind = kind_cur;
        end

        step = '0;
        if (data_emit)
        begin
            step.r0    = data_res;
            step.count = 2'd1;
        end
        if (last)
        begin
            // closing marker takes the next free slot
            if (data_emit)
            begin
                step.r1.item_kind      = KIND_END;
                step.r1.pair_has_value = state_next.in_value_field;
                step.r1.string_done    = 1'b1;
                step.r1.run_last       = 1'b1;
                step.count             = 2'd2;
            end
            else
            begin
                step.r0.item_kind      = KIND_END;
                step.r0.pair_has_value = state_next.in_value_field;
                step.r0.string_done    = 1'b1;
                step.r0.run_last       = 1'b1;
                step.count             = 2'd1;
            end
            state_next = '0;
        end
        else if (data_emit)
        begin
            step.r0.run_last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/qsfd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfd_out_fifo
// Two-entry result queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module qsfd_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  qsfd_pkg::step_t   push,
    input  logic              push_en,
    output logic [1:0]        count,
    output logic              m_tvalid,
    input  logic              m_tready,
    output qsfd_pkg::result_t head
);
    import qsfd_pkg::*;

    result_t    mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] push_cnt;
    logic       pop;

    assign push_cnt = push_en ? push.count : 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        count_next  = count_reg + push_cnt - {1'b0, pop};
        wr_ptr_next = wr_ptr_reg ^ push_cnt[0];
        rd_ptr_next = rd_ptr_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[~wr_ptr_reg] <= push.r1;
        end
    end

endmodule

FILE: sv/query_string_form_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_string_form_decoder
// Percent-decodes a name=value form string and tags name, value and end beats.
// ----------------------------------------------------------------------------
// Path: a beat is registered in the input stage, decoded combinationally and
//   written into the output queue when the queue has room; the queue head drives the output.
// Throughput: one input beat per cycle while each beat yields one result and the
//   output is not stalled; with a result queued, a two-result beat waits until the queue
//   has room for both, and the beat after it waits while the two-entry queue drains.
// Reset: rst_n asynchronously clears the input valid flag, queue count and
//   pointers, and the decode state (name field, no escape pending).
// ----------------------------------------------------------------------------
module query_string_form_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [1:0] item_kind, [2] pair_has_value, [3] string_done
    output logic       m_tlast    // run_last
);
    import qsfd_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       consume;
    logic [1:0] fifo_count;
    logic [2:0] fill_after;
    step_t      step;
    result_t    head;

    qsfd_decode u_decode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ch    (in_byte_reg),
        .last  (in_last_reg),
        .fire  (consume),
        .step  (step)
    );

    qsfd_out_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .push_en  (consume),
        .count    (fifo_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // advance only when the queue has room for every result of the held beat
    assign fill_after = {1'b0, fifo_count} + {1'b0, step.count};
    assign consume    = in_valid_reg && (fill_after <= 3'(FIFO_DEPTH));
    assign s_tready   = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign m_tdata = head.out_byte;
    assign m_tuser = {head.string_done, head.pair_has_value, head.item_kind};
    assign m_tlast = head.run_last;

    a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= 2'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_hold_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_last_reg))
        else $error("stalled input beat lost");

    a_end_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_END |-> m_tdata == 8'd0)
        else $error("end marker carries data");

    a_data_flags : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != KIND_END |-> m_tuser[3:2] == 2'b00)
        else $error("data beat carries end flags");

endmodule
